// ===== src/dcg_pkg.sv =====
// Package for the dwell/cooldown click gate: widths, slot and fire codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package dcg_pkg;

  localparam int TIME_BITS = 32;
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = 2;
  localparam int DWELL_W   = 16;
  localparam int PROG_W    = 9;
  localparam int KIND_W    = 3;
  localparam int REM_W     = DWELL_W + 1;
  localparam int DIV_STEPS = PROG_W;
  localparam int DIV_CNT_W = 4;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 1'b1;

  // slot order: left, right, middle, double
  localparam logic [SLOT_W-1:0] SLOT_LEFT   = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_RIGHT  = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_MIDDLE = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_DOUBLE = 2'd3;

  // fire bit order on the output word: left, double, right, middle
  localparam logic [SLOT_W-1:0] FIRE_LEFT   = 2'd0;
  localparam logic [SLOT_W-1:0] FIRE_DOUBLE = 2'd1;
  localparam logic [SLOT_W-1:0] FIRE_RIGHT  = 2'd2;
  localparam logic [SLOT_W-1:0] FIRE_MIDDLE = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM,
    ST_COMMIT,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic arm;
    logic commit;
    logic scan;
    logic prep;
    logic div;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic scan_last;
    logic div_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [SLOT_W-1:0] fire_pos(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] pos;
    case (slot)
      SLOT_LEFT:   pos = FIRE_LEFT;
      SLOT_RIGHT:  pos = FIRE_RIGHT;
      SLOT_MIDDLE: pos = FIRE_MIDDLE;
      SLOT_DOUBLE: pos = FIRE_DOUBLE;
      default:     pos = FIRE_LEFT;
    endcase
    return pos;
  endfunction

endpackage

// ===== src/dwell_cooldown_click_gate_core.sv =====
// Each word passes the arm, commit, scan, prep, div and load states with the gate on, arm and load
// with dwell_ms zero; the next word is taken only once the last is loaded. The 4-step slot scan and
// the 9-step progress divider set the pace. A waiting result holds the next word only in load.
// Reset (async, active low) clears slots, commit times, preview and both config registers.
// Top level: controller dcg_ctrl and datapath dcg_datapath; uses dcg_pkg.
module dwell_cooldown_click_gate_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] left_click, [1] double_click, [2] right_click, [3] middle_click,
  // [35:4] timestamp_ms, [39:36] zero
  input  logic [dcg_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] fire_left, [1] fire_double, [2] fire_right, [3] fire_middle,
  // [6:4] preview_kind, [15:7] preview_progress_q8, [31:16] preview_remaining_ms
  output logic [dcg_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [dcg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dcg_pkg::DWELL_W-1:0]   cfg_wdata_i
);
  import dcg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign s_axis_tready = in_ready;

  dcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dcg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .capture_i   (s_axis_tvalid && in_ready),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== src/dcg_ctrl.sv =====
// Controller of the click gate: walks one word through arm, commit, slot scan and progress
// division (from arm straight to load when dwell is zero), then hands it to the output register. Uses dcg_pkg.
module dcg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dcg_pkg::dp_status_t status_i,
  output dcg_pkg::dp_cmd_t   cmd_o
);
  import dcg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_ARM;
      ST_ARM:    state_d = status_i.bypass ? ST_LOAD : ST_COMMIT;
      ST_COMMIT: state_d = ST_SCAN;
      ST_SCAN:   if (status_i.scan_last) state_d = ST_PREP;
      ST_PREP:   state_d = ST_DIV;
      ST_DIV:    if (status_i.div_last) state_d = ST_LOAD;
      ST_LOAD:   if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o  = 1'b1;
      ST_ARM:    cmd_o.arm    = 1'b1;
      ST_COMMIT: cmd_o.commit = 1'b1;
      ST_SCAN:   cmd_o.scan   = 1'b1;
      ST_PREP:   cmd_o.prep   = 1'b1;
      ST_DIV:    cmd_o.div    = 1'b1;
      ST_LOAD:   cmd_o.load   = status_i.out_free;
      default:   cmd_o        = '0;
    endcase
  end

endmodule

// ===== src/dcg_datapath.sv =====
// Datapath of the click gate: configuration registers, slot state, preview
// scan, serial progress divider and the output register. Uses dcg_pkg.
module dcg_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dcg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dcg_pkg::DWELL_W-1:0]      cfg_wdata_i,
  input  logic                             capture_i,
  input  logic [dcg_pkg::IN_W-1:0]         in_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [dcg_pkg::OUT_W-1:0]        out_data_o,
  input  dcg_pkg::dp_cmd_t                 cmd_i,
  output dcg_pkg::dp_status_t              status_o
);
  import dcg_pkg::*;

  logic [DWELL_W-1:0]   dwell_q, cooldown_q;
  logic [NUM_SLOTS-1:0] req_q;
  logic [TIME_BITS-1:0] ts_q;
  logic [NUM_SLOTS-1:0] armed_q;
  logic [TIME_BITS-1:0] start_q  [NUM_SLOTS];
  logic [TIME_BITS-1:0] commit_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] fire_q;
  logic [SLOT_W-1:0]    scan_idx_q, best_idx_q;
  logic [TIME_BITS-1:0] best_el_q;
  logic                 best_hit_q;
  logic [REM_W-1:0]     rem_q;
  logic [PROG_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [KIND_W-1:0]    shown_kind_q;
  logic [PROG_W-1:0]    shown_prog_q;
  logic [DWELL_W-1:0]   shown_rem_q;
  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_data_q;

  logic                 bypass;
  logic [NUM_SLOTS-1:0] bypass_fire;
  logic                 pick_any;
  logic [SLOT_W-1:0]    pick;
  logic [TIME_BITS-1:0] pick_el, pick_since, scan_el;
  logic                 commit_ok;
  logic [DWELL_W-1:0]   min_el;
  logic [REM_W-1:0]     trial;
  logic                 trial_ge;
  logic [PROG_W-1:0]    quo_d;
  logic                 out_free;

  assign bypass = (dwell_q == '0);

  // requests in fire order: left, double, right, middle
  assign bypass_fire = {req_q[SLOT_MIDDLE], req_q[SLOT_RIGHT],
                        req_q[SLOT_DOUBLE], req_q[SLOT_LEFT]};

  // firing priority: left, double, right, middle
  always_comb begin
    pick_any = |req_q;
    if (req_q[SLOT_LEFT])        pick = SLOT_LEFT;
    else if (req_q[SLOT_DOUBLE]) pick = SLOT_DOUBLE;
    else if (req_q[SLOT_RIGHT])  pick = SLOT_RIGHT;
    else                         pick = SLOT_MIDDLE;
  end

  assign pick_el    = ts_q - start_q[pick];
  assign pick_since = ts_q - commit_q[pick];
  assign commit_ok  = pick_any && armed_q[pick]
                      && (pick_el >= TIME_BITS'(dwell_q))
                      && ((commit_q[pick] == '0) || (pick_since >= TIME_BITS'(cooldown_q)));

  assign scan_el = ts_q - start_q[scan_idx_q];

  assign min_el = (best_el_q < TIME_BITS'(dwell_q)) ? best_el_q[DWELL_W-1:0] : dwell_q;

  // first step compares the remainder as is, later steps shift it up first
  assign trial    = (div_cnt_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
  assign trial_ge = (trial >= {1'b0, dwell_q});
  assign quo_d    = {quo_q[PROG_W-2:0], trial_ge};

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q    <= '0;
      cooldown_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DWELL:    dwell_q    <= cfg_wdata_i;
        CFG_COOLDOWN: cooldown_q <= cfg_wdata_i;
        default:      dwell_q    <= dwell_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      req_q <= {in_data_i[1], in_data_i[3], in_data_i[2], in_data_i[0]};
      ts_q  <= in_data_i[35:4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      fire_q  <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        start_q[i]  <= '0;
        commit_q[i] <= '0;
      end
    end else if (cmd_i.arm) begin
      if (bypass) begin
        fire_q <= bypass_fire;
      end else begin
        fire_q <= '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (req_q[i]) begin
            if (!armed_q[i]) begin
              armed_q[i] <= 1'b1;
              start_q[i] <= ts_q;
            end
          end else begin
            armed_q[i] <= 1'b0;
          end
        end
      end
    end else if (cmd_i.commit && commit_ok) begin
      commit_q[pick]         <= ts_q;
      armed_q[pick]          <= 1'b0;
      fire_q[fire_pos(pick)] <= 1'b1;
    end
  end

  // preview scan: largest elapsed time among armed slots, earliest slot wins ties
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      scan_idx_q <= '0;
      best_el_q  <= '0;
      best_idx_q <= '0;
      best_hit_q <= 1'b0;
    end else if (cmd_i.scan) begin
      scan_idx_q <= scan_idx_q + 1'b1;
      if (armed_q[scan_idx_q] && (scan_el > best_el_q)) begin
        best_el_q  <= scan_el;
        best_idx_q <= scan_idx_q;
        best_hit_q <= 1'b1;
      end
    end
  end

  // restoring divider: min_el * 256 / dwell, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      rem_q     <= best_hit_q ? {1'b0, min_el} : '0;
      quo_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div) begin
      rem_q     <= trial_ge ? (trial - {1'b0, dwell_q}) : trial;
      quo_q     <= quo_d;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_kind_q <= KIND_NONE;
      shown_prog_q <= '0;
      shown_rem_q  <= '0;
    end else if (cmd_i.prep) begin
      shown_kind_q <= best_hit_q ? (KIND_W'(best_idx_q) + 1'b1) : KIND_NONE;
      shown_rem_q  <= best_hit_q ? (dwell_q - min_el) : '0;
    end else if (cmd_i.div && status_o.div_last) begin
      shown_prog_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= {shown_rem_q, shown_prog_q, shown_kind_q, fire_q};
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;
  assign status_o.bypass    = bypass;
  assign status_o.scan_last = (scan_idx_q == SLOT_W'(NUM_SLOTS - 1));
  assign status_o.div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign status_o.out_free  = out_free;

endmodule

// ===== src/dcg_checker.sv =====
// Port-level checks for the click gate, bound to the top level.
// Uses dcg_pkg.
module dcg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dcg_pkg::OUT_W-1:0]     m_axis_tdata
);
  import dcg_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again during processing");

  a_progress_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:7] <= 9'd256))
    else $error("preview progress above full scale");

  // no preview kind means an all-zero preview
  a_empty_preview: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[6:4] == KIND_NONE) |-> (m_axis_tdata[31:7] == '0))
    else $error("empty preview carries progress or remaining time");

endmodule

bind dwell_cooldown_click_gate_core dcg_checker u_dcg_checker (.*);
